// ===== hdl/tel_pkg.sv =====
// Shared types, constants and the CRC-8 byte step for the event ring logger.
// Used by tel_front, tel_back and throttled_event_ring_logger_top.
package tel_pkg;

    localparam int RING_SLOTS     = 256;
    localparam int SLOTS_PER_PAGE = 128;
    localparam int TYPE_BUCKETS   = 16;

    localparam int SLOT_W     = $clog2(RING_SLOTS);
    localparam int PAGE_SHIFT = $clog2(SLOTS_PER_PAGE);
    localparam int BUCKETS    = TYPE_BUCKETS * 3;
    localparam int BKT_W      = $clog2(BUCKETS);
    localparam int QDEPTH     = 2;

    localparam logic [15:0] REC_MAGIC = 16'h4C45;
    localparam logic [7:0]  CRC_POLY  = 8'h07;
    localparam logic [6:0]  MAX_READ  = 7'd64;
    localparam logic [15:0] WINDOW_RST = 16'd500;
    localparam logic [3:0]  REC_BYTES = 4'd13;

    // Operation codes of an input item
    localparam logic OP_ADD  = 1'b0;
    localparam logic OP_READ = 1'b1;

    // Classified input item as held in the queue
    typedef struct packed {
        logic             op;
        logic [7:0]       event_type;
        logic [7:0]       event_channel;
        logic [7:0]       event_code;
        logic [31:0]      now_ms;
        logic [31:0]      since_seq;
        logic [6:0]       limit;
        logic [BKT_W-1:0] bucket;
    } t_item;

    // One result item
    typedef struct packed {
        logic        kind;
        logic        logged;
        logic        page_cleared;
        logic        entry_valid;
        logic [31:0] entry_seq;
        logic [31:0] entry_time;
        logic [7:0]  entry_type;
        logic [7:0]  entry_channel;
        logic [7:0]  entry_code;
        logic [7:0]  ring_slot;
        logic [7:0]  record_crc;
        logic        last;
    } t_result;

    // One stored ring record
    typedef struct packed {
        logic [31:0] seq;
        logic [31:0] tick;
        logic [23:0] ev;
        logic [7:0]  crc;
    } t_slot_rec;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADD_CHK,
        ST_ADD_DROP,
        ST_CRC,
        ST_ADD_WR,
        ST_RD_ADDR,
        ST_RD_CHK,
        ST_RD_FIN
    } t_state;

    // CRC-8, polynomial 0x07, one byte, most significant bit first.
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// ===== hdl/tel_front.sv =====
// Front end: accepts input items, works out the throttle bucket and the read
// limit, and holds them in a short queue for the back end. Uses tel_pkg.
module tel_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic                 i_op,
    input  logic [7:0]           i_event_type,
    input  logic [7:0]           i_event_channel,
    input  logic [7:0]           i_event_code,
    input  logic [31:0]          i_now_ms,
    input  logic [31:0]          i_since_seq,
    input  logic [6:0]           i_max_count,
    output logic                 o_q_valid,
    output tel_pkg::t_item       o_q_item,
    input  logic                 i_q_pop
);

    tel_pkg::t_item r_q [tel_pkg::QDEPTH];
    logic           r_wp, r_rp;
    logic [1:0]     r_cnt;
    tel_pkg::t_item in_item;
    logic [1:0]     tb_sel;
    logic [tel_pkg::BKT_W-1:0] tb;
    logic           push, pop;

    // Classify the incoming item
    always_comb begin
        tb     = (i_event_type < 8'(tel_pkg::TYPE_BUCKETS)) ? tel_pkg::BKT_W'(i_event_type)
                                                            : '0;
        tb_sel = (i_event_channel > 8'd1) ? 2'd2 : i_event_channel[1:0];
        in_item.op            = i_op;
        in_item.event_type    = i_event_type;
        in_item.event_channel = i_event_channel;
        in_item.event_code    = i_event_code;
        in_item.now_ms        = i_now_ms;
        in_item.since_seq     = i_since_seq;
        in_item.limit         = (i_max_count > tel_pkg::MAX_READ) ? tel_pkg::MAX_READ
                                                                  : i_max_count;
        in_item.bucket        = tel_pkg::BKT_W'(tb * tel_pkg::BKT_W'(3) + tel_pkg::BKT_W'(tb_sel));
    end

    assign o_ready   = (r_cnt != 2'(tel_pkg::QDEPTH));
    assign push      = i_valid && o_ready;
    assign pop       = i_q_pop && (r_cnt != 2'd0);
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_item  = r_q[r_rp];

    // Queue storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= in_item;
        end
    end

    // Queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end

endmodule

// ===== hdl/tel_back.sv =====
// Back end: throttle check, CRC, ring write with page clear, and the read walk.
// Holds the bucket and ring memories; slot occupancy follows from the write
// slot and a wrap flag. Uses tel_pkg.
module tel_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [15:0]          i_window,
    input  logic                 i_q_valid,
    input  tel_pkg::t_item       i_q_item,
    output logic                 o_q_pop,
    input  logic                 i_can_emit,
    output logic                 o_emit,
    output tel_pkg::t_result     o_emit_data
);

    localparam logic [tel_pkg::SLOT_W-1:0] LAST_I = tel_pkg::SLOT_W'(tel_pkg::RING_SLOTS - 1);
    localparam logic [tel_pkg::SLOT_W-1:0] PAGE_MASK =
        tel_pkg::SLOT_W'(tel_pkg::SLOTS_PER_PAGE - 1);

    tel_pkg::t_state    r_state, n_state;
    tel_pkg::t_item     r_item;
    logic [31:0]        bkt_mem [tel_pkg::BUCKETS];
    logic [tel_pkg::BUCKETS-1:0] r_bkt_vld;
    logic [31:0]        r_bkt_q;
    logic               r_bkt_hit;
    tel_pkg::t_slot_rec slot_mem [tel_pkg::RING_SLOTS];
    tel_pkg::t_slot_rec r_slot_q;
    logic               r_wrapped;
    logic [31:0]        r_seq;
    logic [tel_pkg::SLOT_W-1:0] r_wslot, r_i, rd_addr;
    logic [6:0]         r_cnt;
    logic               r_pend_vld;
    tel_pkg::t_result   r_pend;
    logic [103:0]       r_rec;
    logic [7:0]         r_crc;
    logic [3:0]         r_crc_cnt;
    logic               drop, q_ok, rd_stall, rd_done, cleared;
    logic               wslot_at_base, rd_used;
    logic [31:0]        age;
    tel_pkg::t_result   entry_res, add_res;
    tel_pkg::t_slot_rec wr_rec;

    assign rd_addr = r_wslot + r_i;
    assign age     = r_item.now_ms - r_bkt_q;
    assign drop    = r_bkt_hit && (r_bkt_q != 32'd0) && (age < {16'd0, i_window});

    // Slot occupancy. Before the first wrap the slots below the write slot are
    // in use. After it, every slot is in use except those of the write slot's
    // page at or above it, which were freed when the page start was rewritten.
    assign wslot_at_base = ((r_wslot & PAGE_MASK) == '0);
    assign rd_used  = r_wrapped ? (((rd_addr & ~PAGE_MASK) != (r_wslot & ~PAGE_MASK))
                                   || (rd_addr < r_wslot) || wslot_at_base)
                                : (rd_addr < r_wslot);
    assign cleared  = r_wrapped && wslot_at_base;

    assign q_ok    = rd_used && (r_slot_q.seq != 32'd0)
                     && (r_slot_q.seq > r_item.since_seq);
    assign rd_stall = q_ok && r_pend_vld && !i_can_emit;
    assign rd_done  = (q_ok && ((r_cnt + 7'd1) == r_item.limit)) || (r_i == LAST_I);

    // Result built from the ring entry under the walk
    always_comb begin
        entry_res               = '0;
        entry_res.kind          = 1'b1;
        entry_res.entry_valid   = 1'b1;
        entry_res.entry_seq     = r_slot_q.seq;
        entry_res.entry_time    = r_slot_q.tick;
        entry_res.entry_type    = r_slot_q.ev[7:0];
        entry_res.entry_channel = r_slot_q.ev[15:8];
        entry_res.entry_code    = r_slot_q.ev[23:16];
        entry_res.ring_slot     = 8'(rd_addr);
        entry_res.record_crc    = r_slot_q.crc;
    end

    // Add status for a logged event, and the record to store
    always_comb begin
        add_res              = '0;
        add_res.logged       = 1'b1;
        add_res.page_cleared = cleared;
        add_res.entry_seq    = r_seq;
        add_res.ring_slot    = 8'(r_wslot);
        add_res.record_crc   = r_crc;
        add_res.last         = 1'b1;
        wr_rec.seq  = r_seq;
        wr_rec.tick = r_item.now_ms;
        wr_rec.ev   = {r_item.event_code, r_item.event_channel, r_item.event_type};
        wr_rec.crc  = r_crc;
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tel_pkg::ST_IDLE: begin
                if (i_q_valid) begin
                    if (i_q_item.op == tel_pkg::OP_ADD) begin
                        n_state = tel_pkg::ST_ADD_CHK;
                    end else if (i_q_item.limit == 7'd0) begin
                        n_state = tel_pkg::ST_RD_FIN;
                    end else begin
                        n_state = tel_pkg::ST_RD_ADDR;
                    end
                end
            end
            tel_pkg::ST_ADD_CHK:  n_state = drop ? tel_pkg::ST_ADD_DROP : tel_pkg::ST_CRC;
            tel_pkg::ST_ADD_DROP: if (i_can_emit) n_state = tel_pkg::ST_IDLE;
            tel_pkg::ST_CRC: begin
                if (r_crc_cnt == tel_pkg::REC_BYTES - 4'd1) begin
                    n_state = tel_pkg::ST_ADD_WR;
                end
            end
            tel_pkg::ST_ADD_WR:   if (i_can_emit) n_state = tel_pkg::ST_IDLE;
            tel_pkg::ST_RD_ADDR:  n_state = tel_pkg::ST_RD_CHK;
            tel_pkg::ST_RD_CHK: begin
                if (!rd_stall) begin
                    n_state = rd_done ? tel_pkg::ST_RD_FIN : tel_pkg::ST_RD_ADDR;
                end
            end
            tel_pkg::ST_RD_FIN:   if (i_can_emit) n_state = tel_pkg::ST_IDLE;
            default:              n_state = tel_pkg::ST_IDLE;
        endcase
    end

    // Outputs of the state machine
    always_comb begin
        o_q_pop     = 1'b0;
        o_emit      = 1'b0;
        o_emit_data = '0;
        unique case (r_state)
            tel_pkg::ST_IDLE:     o_q_pop = i_q_valid;
            tel_pkg::ST_ADD_DROP: begin
                o_emit           = i_can_emit;
                o_emit_data.last = 1'b1;
            end
            tel_pkg::ST_ADD_WR: begin
                o_emit      = i_can_emit;
                o_emit_data = add_res;
            end
            tel_pkg::ST_RD_CHK: begin
                o_emit      = q_ok && r_pend_vld && i_can_emit;
                o_emit_data = r_pend;
            end
            tel_pkg::ST_RD_FIN: begin
                o_emit = i_can_emit;
                if (r_pend_vld) begin
                    o_emit_data      = r_pend;
                    o_emit_data.last = 1'b1;
                end else begin
                    o_emit_data.kind = 1'b1;
                    o_emit_data.last = 1'b1;
                end
            end
            default: ;
        endcase
    end

    // Memories with registered reads
    always_ff @(posedge i_clk) begin
        r_bkt_q   <= bkt_mem[i_q_item.bucket];
        r_bkt_hit <= r_bkt_vld[i_q_item.bucket];
        r_slot_q  <= slot_mem[rd_addr];
        if (r_state == tel_pkg::ST_ADD_CHK && !drop) begin
            bkt_mem[r_item.bucket] <= (r_item.now_ms == 32'd0) ? 32'd1 : r_item.now_ms;
        end
        if (r_state == tel_pkg::ST_ADD_WR && i_can_emit) begin
            slot_mem[r_wslot] <= wr_rec;
        end
    end

    // Item, CRC and walk datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            tel_pkg::ST_IDLE: begin
                if (i_q_valid) begin
                    r_item <= i_q_item;
                end
            end
            tel_pkg::ST_ADD_CHK: begin
                r_rec     <= {r_item.event_code, r_item.event_channel, r_item.event_type,
                              r_item.now_ms, r_seq, tel_pkg::REC_MAGIC};
                r_crc     <= 8'd0;
                r_crc_cnt <= 4'd0;
            end
            tel_pkg::ST_CRC: begin
                r_crc     <= tel_pkg::crc8_byte(r_crc, r_rec[7:0]);
                r_rec     <= {8'd0, r_rec[103:8]};
                r_crc_cnt <= r_crc_cnt + 4'd1;
            end
            tel_pkg::ST_RD_CHK: begin
                if (!rd_stall && q_ok) begin
                    r_pend <= entry_res;
                end
            end
            default: ;
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= tel_pkg::ST_IDLE;
            r_bkt_vld  <= '0;
            r_wrapped  <= 1'b0;
            r_seq      <= 32'd1;
            r_wslot    <= '0;
            r_i        <= '0;
            r_cnt      <= 7'd0;
            r_pend_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            case (r_state)
                tel_pkg::ST_IDLE: begin
                    r_i        <= '0;
                    r_cnt      <= 7'd0;
                    r_pend_vld <= 1'b0;
                end
                tel_pkg::ST_ADD_CHK: begin
                    if (!drop) begin
                        r_bkt_vld[r_item.bucket] <= 1'b1;
                    end
                end
                tel_pkg::ST_ADD_WR: begin
                    if (i_can_emit) begin
                        // Claim the slot; the ring has wrapped once the last slot is written
                        if (r_wslot == LAST_I) begin
                            r_wrapped <= 1'b1;
                        end
                        r_seq   <= r_seq + 32'd1;
                        r_wslot <= r_wslot + tel_pkg::SLOT_W'(1);
                    end
                end
                tel_pkg::ST_RD_CHK: begin
                    if (!rd_stall) begin
                        r_i <= r_i + tel_pkg::SLOT_W'(1);
                        if (q_ok) begin
                            r_pend_vld <= 1'b1;
                            r_cnt      <= r_cnt + 7'd1;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

endmodule

// ===== hdl/throttled_event_ring_logger_top.sv =====
// Throttled event ring logger: a throttled add is answered after the bucket
// check; a logged add first runs a bytewise CRC over the 13-byte record. A read
// walks the ring slot by slot (one registered ring-memory read and one check
// per slot) over at most 256 slots, and stalls while results wait.
// Slot occupancy follows from the write slot and a wrap flag, and the bucket
// valid bits clear at reset, so no clearing pass is needed. Results leave
// through an output register.
module throttled_event_ring_logger_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_op,
    input  logic [7:0]  i_event_type,
    input  logic [7:0]  i_event_channel,
    input  logic [7:0]  i_event_code,
    input  logic [31:0] i_now_ms,
    input  logic [31:0] i_since_seq,
    input  logic [6:0]  i_max_count,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_kind,
    output logic        o_logged,
    output logic        o_page_cleared,
    output logic        o_entry_valid,
    output logic [31:0] o_entry_seq,
    output logic [31:0] o_entry_time,
    output logic [7:0]  o_entry_type,
    output logic [7:0]  o_entry_channel,
    output logic [7:0]  o_entry_code,
    output logic [7:0]  o_ring_slot,
    output logic [7:0]  o_record_crc,
    output logic        o_last
);

    logic             q_valid, q_pop, emit, can_emit;
    tel_pkg::t_item   q_item;
    tel_pkg::t_result emit_data, r_out;
    logic             r_out_vld;
    logic [15:0]      r_window;

    tel_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_op           (i_op),
        .i_event_type   (i_event_type),
        .i_event_channel(i_event_channel),
        .i_event_code   (i_event_code),
        .i_now_ms       (i_now_ms),
        .i_since_seq    (i_since_seq),
        .i_max_count    (i_max_count),
        .o_q_valid      (q_valid),
        .o_q_item       (q_item),
        .i_q_pop        (q_pop)
    );

    tel_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_window   (r_window),
        .i_q_valid  (q_valid),
        .i_q_item   (q_item),
        .o_q_pop    (q_pop),
        .i_can_emit (can_emit),
        .o_emit     (emit),
        .o_emit_data(emit_data)
    );

    // Throttle window register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= tel_pkg::WINDOW_RST;
        end else if (i_cfg_we) begin
            r_window <= i_cfg_wdata;
        end
    end

    // Output register; a new item loads it as the old one is taken.
    assign can_emit = !r_out_vld || i_ready;

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out <= emit_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (emit) begin
            r_out_vld <= 1'b1;
        end else if (i_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    assign o_valid         = r_out_vld;
    assign o_kind          = r_out.kind;
    assign o_logged        = r_out.logged;
    assign o_page_cleared  = r_out.page_cleared;
    assign o_entry_valid   = r_out.entry_valid;
    assign o_entry_seq     = r_out.entry_seq;
    assign o_entry_time    = r_out.entry_time;
    assign o_entry_type    = r_out.entry_type;
    assign o_entry_channel = r_out.entry_channel;
    assign o_entry_code    = r_out.entry_code;
    assign o_ring_slot     = r_out.ring_slot;
    assign o_record_crc    = r_out.record_crc;
    assign o_last          = r_out.last;

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the throttled event ring logger: a stimulus table,
// then random adds and reads, each result checked against a behavioural copy.
// Depends on tel_pkg and throttled_event_ring_logger_top.
module tb_top;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [15:0] i_cfg_wdata = '0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic        i_op = tel_pkg::OP_ADD;
    logic [7:0]  i_event_type = '0;
    logic [7:0]  i_event_channel = '0;
    logic [7:0]  i_event_code = '0;
    logic [31:0] i_now_ms = '0;
    logic [31:0] i_since_seq = '0;
    logic [6:0]  i_max_count = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic        o_kind, o_logged, o_page_cleared, o_entry_valid, o_last;
    logic [31:0] o_entry_seq, o_entry_time;
    logic [7:0]  o_entry_type, o_entry_channel, o_entry_code, o_ring_slot, o_record_crc;

    throttled_event_ring_logger_top u_top (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Behavioural copy of the logger state.
    logic [15:0]        window_ms;
    logic [31:0]        bucket_tick [tel_pkg::BUCKETS];
    logic [31:0]        seq_next;
    logic [7:0]         wr_slot;
    logic               used [tel_pkg::RING_SLOTS];
    tel_pkg::t_slot_rec ring [tel_pkg::RING_SLOTS];

    tel_pkg::t_result expected_q[$];
    int      n_fail = 0;
    logic    stall_long = 1'b0;

    typedef struct {
        logic        op;
        logic [7:0]  ty, ch, cd;
        logic [31:0] now, since;
        logic [6:0]  cnt;
        logic        chk_fixed;
        tel_pkg::t_result fixed;
    } t_row;

    function automatic logic [7:0] record_crc(logic [31:0] s, logic [31:0] t, logic [23:0] ev);
        logic [103:0] rec;
        logic [7:0]   c;
        logic [7:0]   b;
        rec = {ev, t, s, tel_pkg::REC_MAGIC};
        c = 8'h00;
        for (int i = 0; i < 13; i++) begin
            b = rec[i*8 +: 8];
            c = c ^ b;
            for (int k = 0; k < 8; k++)
                c = c[7] ? ({c[6:0], 1'b0} ^ tel_pkg::CRC_POLY) : {c[6:0], 1'b0};
        end
        return c;
    endfunction

    function automatic void clear_model();
        window_ms = tel_pkg::WINDOW_RST;
        seq_next = 32'd1;
        wr_slot = '0;
        foreach (bucket_tick[i]) bucket_tick[i] = '0;
        foreach (used[i]) begin
            used[i] = 1'b0;
            ring[i] = '0;
        end
    endfunction

    // Works out the results of one accepted item and queues them.
    function automatic void predict_logger(t_row r);
        tel_pkg::t_result res;
        int      bi, lim, n;
        logic [7:0] sl;
        res = '0;
        if (r.op == tel_pkg::OP_ADD) begin
            res.last = 1'b1;
            bi = ((r.ty < tel_pkg::TYPE_BUCKETS) ? int'(r.ty) : 0) * 3
                 + ((r.ch > 8'd1) ? 2 : int'(r.ch));
            if (!(bucket_tick[bi] != 0 && (r.now - bucket_tick[bi]) < {16'd0, window_ms})) begin
                bucket_tick[bi] = (r.now == 0) ? 32'd1 : r.now;
                sl = wr_slot;
                if (used[sl]) begin
                    for (int s = (int'(sl) / tel_pkg::SLOTS_PER_PAGE) * tel_pkg::SLOTS_PER_PAGE;
                         s < (int'(sl) / tel_pkg::SLOTS_PER_PAGE + 1) * tel_pkg::SLOTS_PER_PAGE
                         && s < tel_pkg::RING_SLOTS; s++)
                        used[s] = 1'b0;
                    res.page_cleared = 1'b1;
                end
                used[sl] = 1'b1;
                ring[sl].seq = seq_next;
                ring[sl].tick = r.now;
                ring[sl].ev = {r.cd, r.ch, r.ty};
                ring[sl].crc = record_crc(seq_next, r.now, {r.cd, r.ch, r.ty});
                res.logged = 1'b1;
                res.entry_seq = seq_next;
                res.ring_slot = sl;
                res.record_crc = ring[sl].crc;
                seq_next = seq_next + 32'd1;
                wr_slot = sl + 8'd1;
            end
            expected_q.push_back(res);
        end else begin
            lim = (r.cnt > tel_pkg::MAX_READ) ? int'(tel_pkg::MAX_READ) : int'(r.cnt);
            n = 0;
            for (int i = 0; i < tel_pkg::RING_SLOTS && n < lim; i++) begin
                sl = 8'(int'(wr_slot) + i);
                if (used[sl] && ring[sl].seq != 0 && ring[sl].seq > r.since) begin
                    res = '0;
                    res.kind = 1'b1;
                    res.entry_valid = 1'b1;
                    res.entry_seq = ring[sl].seq;
                    res.entry_time = ring[sl].tick;
                    {res.entry_code, res.entry_channel, res.entry_type} = ring[sl].ev;
                    res.ring_slot = sl;
                    res.record_crc = ring[sl].crc;
                    expected_q.push_back(res);
                    n++;
                end
            end
            if (n == 0) begin
                res = '0;
                res.kind = 1'b1;
                res.last = 1'b1;
                expected_q.push_back(res);
            end else begin
                expected_q[$].last = 1'b1;
            end
        end
    endfunction

    // Offers one item, waiting a random gap first and holding it until taken.
    // Valid stays high on return so that a back-to-back item needs no gap.
    task automatic offer_item(t_row r);
        int gap;
        gap = $urandom_range(0, 4);
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_op <= r.op;
        i_event_type <= r.ty;
        i_event_channel <= r.ch;
        i_event_code <= r.cd;
        i_now_ms <= r.now;
        i_since_seq <= r.since;
        i_max_count <= r.cnt;
        do @(posedge i_clk); while (!o_ready);
        predict_logger(r);
        if (r.chk_fixed && expected_q[$] != r.fixed) begin
            $error("table row: expected 0x%0h, predicted 0x%0h", r.fixed, expected_q[$]);
            n_fail++;
        end
    endtask

    // Writes the throttle window once everything outstanding has drained.
    task automatic set_window(logic [15:0] w);
        i_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= w;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        window_ms = w;
    endtask

    function automatic t_row add_row(logic [7:0] ty, logic [7:0] ch, logic [7:0] cd,
                                     logic [31:0] now);
        t_row r;
        r = '{tel_pkg::OP_ADD, ty, ch, cd, now, 32'd0, 7'd0, 1'b0, '0};
        return r;
    endfunction

    function automatic t_row read_row(logic [31:0] since, logic [6:0] cnt);
        t_row r;
        r = '{tel_pkg::OP_READ, 8'd0, 8'd0, 8'd0, 32'd0, since, cnt, 1'b0, '0};
        return r;
    endfunction

    // Random item: mostly adds with a moving clock, some reads.
    function automatic t_row random_row(ref logic [31:0] clk_ms);
        t_row r;
        clk_ms = clk_ms + $urandom_range(0, 400);
        if ($urandom_range(0, 9) < 7) begin
            r = add_row($urandom_range(0, 3) == 0 ? 8'($urandom) : 8'($urandom_range(0, 17)),
                        $urandom_range(0, 3) == 0 ? 8'($urandom) : 8'($urandom_range(0, 2)),
                        8'($urandom), ($urandom_range(0, 15) == 0) ? $urandom : clk_ms);
        end else begin
            r = read_row(($urandom_range(0, 1) == 0) ? seq_next - $urandom_range(0, 20)
                                                     : $urandom,
                         $urandom_range(0, 3) == 0 ? 7'($urandom) : 7'($urandom_range(0, 4)));
        end
        return r;
    endfunction

    // Result side: a random wait before each item, and one
    // long hold-off on request.
    initial begin
        tel_pkg::t_result got, exp_r;
        int idle_left;
        idle_left = $urandom_range(0, 4);
        forever begin
            @(posedge i_clk);
            if (i_ready && o_valid) begin
                got = '{o_kind, o_logged, o_page_cleared, o_entry_valid, o_entry_seq,
                        o_entry_time, o_entry_type, o_entry_channel, o_entry_code,
                        o_ring_slot, o_record_crc, o_last};
                idle_left = $urandom_range(0, 4);
                if (expected_q.size() == 0) begin
                    $error("result 0x%0h arrived with nothing expected", got);
                    n_fail++;
                end else begin
                    exp_r = expected_q.pop_front();
                    if (got.kind != exp_r.kind) begin
                        $error("kind: expected %0d, got %0d", exp_r.kind, got.kind); n_fail++;
                    end
                    if (got.logged != exp_r.logged) begin
                        $error("logged: expected %0d, got %0d", exp_r.logged, got.logged); n_fail++;
                    end
                    if (got.page_cleared != exp_r.page_cleared) begin
                        $error("page_cleared: expected %0d, got %0d",
                               exp_r.page_cleared, got.page_cleared); n_fail++;
                    end
                    if (got.entry_valid != exp_r.entry_valid) begin
                        $error("entry_valid: expected %0d, got %0d",
                               exp_r.entry_valid, got.entry_valid); n_fail++;
                    end
                    if (got.entry_seq != exp_r.entry_seq) begin
                        $error("entry_seq: expected %0h, got %0h", exp_r.entry_seq, got.entry_seq);
                        n_fail++;
                    end
                    if (got.entry_time != exp_r.entry_time) begin
                        $error("entry_time: expected %0h, got %0h",
                               exp_r.entry_time, got.entry_time); n_fail++;
                    end
                    if (got.entry_type != exp_r.entry_type) begin
                        $error("entry_type: expected %0h, got %0h",
                               exp_r.entry_type, got.entry_type); n_fail++;
                    end
                    if (got.entry_channel != exp_r.entry_channel) begin
                        $error("entry_channel: expected %0h, got %0h",
                               exp_r.entry_channel, got.entry_channel); n_fail++;
                    end
                    if (got.entry_code != exp_r.entry_code) begin
                        $error("entry_code: expected %0h, got %0h",
                               exp_r.entry_code, got.entry_code); n_fail++;
                    end
                    if (got.ring_slot != exp_r.ring_slot) begin
                        $error("ring_slot: expected %0d, got %0d", exp_r.ring_slot, got.ring_slot);
                        n_fail++;
                    end
                    if (got.record_crc != exp_r.record_crc) begin
                        $error("record_crc: expected %0h, got %0h",
                               exp_r.record_crc, got.record_crc); n_fail++;
                    end
                    if (got.last != exp_r.last) begin
                        $error("last: expected %0d, got %0d", exp_r.last, got.last); n_fail++;
                    end
                end
            end else if (idle_left > 0) begin
                idle_left--;
            end
            if (stall_long) begin
                i_ready <= 1'b0;
                repeat (600) @(posedge i_clk);
                stall_long = 1'b0;
            end
            i_ready <= (idle_left == 0);
        end
    end

    // Stimulus.
    initial begin
        t_row        dir_tbl[$];
        t_row        r;
        logic [31:0] clk_ms;
        logic [15:0] windows [4];
        clear_model();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table: empty store, extremes, throttling, bucket folding.
        r = read_row(32'd0, 7'd64);
        r.chk_fixed = 1'b1;
        r.fixed = '0; r.fixed.kind = 1'b1; r.fixed.last = 1'b1;
        dir_tbl.push_back(r);
        dir_tbl.push_back(add_row(8'd0, 8'd0, 8'd0, 32'd0));
        r = add_row(8'd0, 8'd0, 8'hFF, 32'd1);            // inside window: dropped
        r.chk_fixed = 1'b1;
        r.fixed = '0; r.fixed.last = 1'b1;
        dir_tbl.push_back(r);
        dir_tbl.push_back(add_row(8'hFF, 8'hFF, 8'hFF, 32'hFFFF_FFFF));
        dir_tbl.push_back(add_row(8'd16, 8'd1, 8'h5A, 32'd1000)); // folds to type bucket 0
        dir_tbl.push_back(add_row(8'd15, 8'd2, 8'hA5, 32'd1200));
        dir_tbl.push_back(add_row(8'd15, 8'd200, 8'h11, 32'd1300)); // same bucket, dropped
        dir_tbl.push_back(add_row(8'd15, 8'd2, 8'h22, 32'd1700));   // exactly at window
        dir_tbl.push_back(add_row(8'd7, 8'd1, 8'h33, 32'h8000_0000));
        dir_tbl.push_back(read_row(32'd0, 7'd127));
        dir_tbl.push_back(read_row(32'd0, 7'd0));
        dir_tbl.push_back(read_row(32'd2, 7'd2));
        dir_tbl.push_back(read_row(32'hFFFF_FFFF, 7'd10));
        dir_tbl.push_back(read_row(32'h7FFF_FFFF, 7'd1));
        foreach (dir_tbl[i]) offer_item(dir_tbl[i]);

        // Window extremes, then random items under each.
        windows = '{16'd0, 16'hFFFF, 16'd1, 16'd300};
        clk_ms = 32'd5000;
        for (int p = 0; p < 4; p++) begin
            set_window(windows[p]);
            if (p == 1) stall_long = 1'b1;
            for (int i = 0; i < 30; i++) offer_item(random_row(clk_ms));
            // Run of adds with scattered ticks to fill a good part of the ring.
            if (p == 0) for (int i = 0; i < 86; i++)
                offer_item(add_row(8'($urandom), 8'($urandom), 8'($urandom), $urandom));
            if (p == 2) for (int i = 0; i < 3; i++) offer_item(read_row($urandom_range(0, 1), 7'd64));
        end
        i_valid <= 1'b0;

        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (600) @(posedge i_clk);
        if (n_fail == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Watchdog.
    initial begin
        #20ms;
        $display("Some tests failed");
        $finish;
    end
endmodule
